[src/fbfe_pkg.sv]
// Shared types and constants for the framed byte to FSK symbol encoder.
`timescale 1ns / 1ps
`default_nettype none

package fbfe_pkg;

   localparam logic [7:0] FRAME_FLAG  = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
   localparam logic [7:0] ESCAPE_XOR  = 8'h20;
   localparam logic [7:0] FILL_BYTE   = 8'h00;

   localparam int unsigned DIGITS_PER_BYTE = 3;

   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_DATA  = 2'd1,
      OP_EMPTY = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FLAG = 6'b000010,
      ST_LEN  = 6'b000100,
      ST_DATA = 6'b001000,
      ST_CHK  = 6'b010000,
      ST_FILL = 6'b100000
   } frm_state_type;

   // one byte handed from the framer to the serializer
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } byte_word_type;

endpackage

`default_nettype wire

[src/framed_byte_to_fsk_symbol_encoder.sv]
// Top level of the framed byte to FSK symbol encoder.
// Each request word yields one to seven bytes (filler; or flag, length, data,
// checksum, any of the last three possibly escaped), and every byte leaves as
// four symbols, one per cycle unless the symbol port stalls or no request is
// waiting. The digit serializer shifts out the byte's 3-bit digits, low digit
// first, behind a start symbol. The framer takes the next request as soon as it
// has handed its last byte to the serializer, and the output register holds a
// symbol under backpressure while the serializer waits.
`timescale 1ns / 1ps
`default_nettype none

module framed_byte_to_fsk_symbol_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_first,
   input  wire logic       req_last,
   input  wire logic [7:0] req_packet_length,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_symbol,
   output logic            rsp_last_of_run
);

   logic                    byte_valid;
   logic                    byte_ready;
   fbfe_pkg::byte_word_type byte_word;

   fbfe_framer u_framer (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .req_first         (req_first),
      .req_last          (req_last),
      .req_packet_length (req_packet_length),
      .byte_valid        (byte_valid),
      .byte_ready        (byte_ready),
      .byte_word         (byte_word)
   );

   fbfe_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (byte_valid),
      .byte_ready      (byte_ready),
      .byte_word       (byte_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[src/fbfe_framer.sv]
// Frame builder: flag, length, data, checksum, with byte stuffing; filler for idle and reserved words.
`timescale 1ns / 1ps
`default_nettype none

module fbfe_framer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_op,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_first,
   input  wire logic                   req_last,
   input  wire logic [7:0]             req_packet_length,
   output logic                        byte_valid,
   input  wire logic                   byte_ready,
   output fbfe_pkg::byte_word_type     byte_word
);

   fbfe_pkg::frm_state_type state_ff, state_in;
   logic       esc_ff, esc_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] chk_ff, chk_in;
   logic       has_data_ff, has_data_in;
   logic       has_chk_ff, has_chk_in;

   logic [7:0] cur_byte;
   logic       stuffable;
   logic       need_esc;
   logic       final_byte;
   fbfe_pkg::frm_state_type next_state;
   logic       accept;
   logic       fire;
   logic [7:0] new_sum;

   assign req_ready  = (state_ff == fbfe_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign byte_valid = (state_ff != fbfe_pkg::ST_IDLE);
   assign fire       = byte_valid && byte_ready;

   always_comb begin
      cur_byte   = fbfe_pkg::FILL_BYTE;
      stuffable  = 1'b0;
      final_byte = 1'b0;
      next_state = fbfe_pkg::ST_IDLE;
      unique case (state_ff)
         fbfe_pkg::ST_FLAG: begin
            cur_byte   = fbfe_pkg::FRAME_FLAG;
            next_state = fbfe_pkg::ST_LEN;
         end
         fbfe_pkg::ST_LEN: begin
            cur_byte   = len_ff;
            stuffable  = 1'b1;
            next_state = has_data_ff ? fbfe_pkg::ST_DATA : fbfe_pkg::ST_CHK;
         end
         fbfe_pkg::ST_DATA: begin
            cur_byte   = data_ff;
            stuffable  = 1'b1;
            final_byte = !has_chk_ff;
            next_state = has_chk_ff ? fbfe_pkg::ST_CHK : fbfe_pkg::ST_IDLE;
         end
         fbfe_pkg::ST_CHK: begin
            cur_byte   = chk_ff;
            stuffable  = 1'b1;
            final_byte = 1'b1;
         end
         fbfe_pkg::ST_FILL: begin
            final_byte = 1'b1;
         end
         default: begin
            cur_byte = fbfe_pkg::FILL_BYTE;
         end
      endcase
   end

   assign need_esc = stuffable &&
                     (cur_byte == fbfe_pkg::FRAME_FLAG || cur_byte == fbfe_pkg::ESCAPE_BYTE);

   always_comb begin
      byte_word.value = cur_byte;
      if (need_esc && !esc_ff) begin
         byte_word.value = fbfe_pkg::ESCAPE_BYTE;
      end else if (esc_ff) begin
         byte_word.value = cur_byte ^ fbfe_pkg::ESCAPE_XOR;
      end
      byte_word.last = final_byte && !(need_esc && !esc_ff);
   end

   // sum the packet as it is accepted; checksum is 0xFF minus the sum
   always_comb begin
      new_sum = sum_ff + req_data_byte;
      if (req_first) begin
         new_sum = req_packet_length + req_data_byte;
      end
   end

   always_comb begin
      state_in    = state_ff;
      esc_in      = esc_ff;
      sum_in      = sum_ff;
      len_in      = len_ff;
      data_in     = data_ff;
      chk_in      = chk_ff;
      has_data_in = has_data_ff;
      has_chk_in  = has_chk_ff;
      if (accept) begin
         esc_in      = 1'b0;
         data_in     = req_data_byte;
         len_in      = req_packet_length;
         has_data_in = 1'b1;
         has_chk_in  = req_last;
         unique case (fbfe_pkg::op_type'(req_op))
            fbfe_pkg::OP_DATA: begin
               sum_in   = new_sum;
               chk_in   = ~new_sum;
               state_in = req_first ? fbfe_pkg::ST_FLAG : fbfe_pkg::ST_DATA;
            end
            fbfe_pkg::OP_EMPTY: begin
               sum_in      = 8'h00;
               chk_in      = 8'hFF;
               len_in      = 8'h00;
               has_data_in = 1'b0;
               has_chk_in  = 1'b1;
               state_in    = fbfe_pkg::ST_FLAG;
            end
            fbfe_pkg::OP_IDLE, fbfe_pkg::OP_RSVD: begin
               state_in = fbfe_pkg::ST_FILL;
            end
            default: begin
               state_in = fbfe_pkg::ST_FILL;
            end
         endcase
      end else if (fire) begin
         if (need_esc && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            esc_in   = 1'b0;
            state_in = next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbfe_pkg::ST_IDLE;
         esc_ff   <= 1'b0;
         sum_ff   <= 8'h00;
      end else begin
         state_ff <= state_in;
         esc_ff   <= esc_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      data_ff     <= data_in;
      chk_ff      <= chk_in;
      has_data_ff <= has_data_in;
      has_chk_ff  <= has_chk_in;
   end

endmodule

`default_nettype wire

[src/fbfe_serializer.sv]
// Digit serializer: start symbol then three 3-bit digits per byte, one per cycle when not stalled.
`timescale 1ns / 1ps
`default_nettype none

module fbfe_serializer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_valid,
   output logic                        byte_ready,
   input  wire fbfe_pkg::byte_word_type byte_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [3:0]                  rsp_symbol,
   output logic                        rsp_last_of_run
);

   logic       busy_ff, busy_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] shreg_ff, shreg_in;
   logic       last_ff, last_in;
   logic [3:0] prev_ff, prev_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_sym_ff, out_sym_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic       final_digit;
   logic [3:0] digit_sym;
   logic       load;

   assign advance     = !out_valid_ff || rsp_ready;
   assign final_digit = (cnt_ff == 2'(fbfe_pkg::DIGITS_PER_BYTE));
   assign byte_ready  = !busy_ff || (advance && final_digit);
   assign load        = byte_valid && byte_ready;

   // digit goes out as d+1, bumped once more when not below the prior symbol so it never repeats it
   always_comb begin
      digit_sym = {1'b0, shreg_ff[2:0]} + 4'd1;
      if (digit_sym >= prev_ff) begin
         digit_sym = digit_sym + 4'd1;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      shreg_in     = shreg_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      out_valid_in = out_valid_ff;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            if (cnt_ff == 2'd0) begin
               out_sym_in = 4'd0;
            end else begin
               out_sym_in = digit_sym;
               shreg_in   = {3'b000, shreg_ff[7:3]};
            end
            prev_in     = out_sym_in;
            out_last_in = last_ff && final_digit;
            cnt_in      = cnt_ff + 2'd1;
            if (final_digit) begin
               busy_in = 1'b0;
            end
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = 2'd0;
         shreg_in = byte_word.value;
         last_in  = byte_word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= 2'd0;
         prev_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      last_ff     <= last_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol      = out_sym_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

[dv/framed_byte_to_fsk_symbol_encoder_test.sv]
// Testbench for the framed byte to FSK symbol encoder: table plus random frames vs predictor.
`timescale 1ns / 1ps

module framed_byte_to_fsk_symbol_encoder_test;

   localparam logic [7:0] CHECK_BASE  = 8'hFF;
   localparam int         WATCH_LIMIT = 4000;
   localparam int         HOLD_CYCLES = 250;
   localparam int         DRAIN_WAIT  = 40;
   localparam int         RAND_WORDS  = 300;

   // tone sequences readable at a glance, first tone in the low nibble
   localparam logic [47:0] FILL_TONES  = 48'h2120;          // byte 0x00
   localparam logic [47:0] FF_TONES    = 48'h4890;          // byte 0xFF
   localparam logic [47:0] EMPTY_TONES = 48'h489021202980;  // 7E, 00, FF

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [7:0]  len;
      logic [3:0]  n_typed;   // 0: take the predictor's tones
      logic [47:0] typed;
   } req_word_type;

   typedef struct {
      logic [3:0] tone;
      logic       run_end;
      int         word_idx;
   } tone_exp_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_op = '0;
   logic [7:0] req_data_byte = '0;
   logic       req_first = 1'b0;
   logic       req_last = 1'b0;
   logic [7:0] req_packet_length = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_symbol;
   logic       rsp_last_of_run;

   framed_byte_to_fsk_symbol_encoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .req_first         (req_first),
      .req_last          (req_last),
      .req_packet_length (req_packet_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol        (rsp_symbol),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // predictor state
   logic [3:0]   last_tone = '0;
   logic [7:0]   frame_sum = '0;
   logic [3:0]   tone_buf[$];
   tone_exp_type tone_q[$];

   req_word_type word_q[$];
   int           dir_n = 0;
   int           mismatches = 0;
   int           words_sent = 0;
   int           tones_checked = 0;
   int           frames_opened = 0;
   int           escapes_seen = 0;
   int           idle_cycles = 0;
   bit           hold_asked = 0;
   bit           hold_done = 0;
   bit           rsp_held = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic req_word_type mk_word(logic [1:0] op, logic [7:0] data, logic first,
                                            logic last, logic [7:0] len, logic [3:0] n_typed,
                                            logic [47:0] typed);
      req_word_type w;
      w.op = op;
      w.data = data;
      w.first = first;
      w.last = last;
      w.len = len;
      w.n_typed = n_typed;
      w.typed = typed;
      return w;
   endfunction

   // random content in every field, including those the op ignores
   function automatic req_word_type junk_word(logic [1:0] op);
      return mk_word(op, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 4'd0, '0);
   endfunction

   // payload biased toward the bytes that need escaping
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return fbfe_pkg::FRAME_FLAG;
         1: return fbfe_pkg::ESCAPE_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic encode_byte(input logic [7:0] b);
      logic [7:0] rest;
      logic [3:0] t;
      rest = b;
      tone_buf.push_back(4'd0);
      last_tone = 4'd0;
      for (int k = 0; k < fbfe_pkg::DIGITS_PER_BYTE; k++) begin
         t = {1'b0, rest[2:0]} + 4'd1;
         rest = rest >> 3;
         if (t >= last_tone)
            t = t + 4'd1;
         tone_buf.push_back(t);
         last_tone = t;
      end
   endtask

   task automatic encode_stuffed(input logic [7:0] b);
      if (b == fbfe_pkg::FRAME_FLAG || b == fbfe_pkg::ESCAPE_BYTE) begin
         escapes_seen++;
         encode_byte(fbfe_pkg::ESCAPE_BYTE);
         encode_byte(b ^ fbfe_pkg::ESCAPE_XOR);
      end else begin
         encode_byte(b);
      end
   endtask

   // tones for one accepted word; updates frame state
   task automatic predict_tones(input req_word_type w, input int idx);
      tone_exp_type e;
      tone_buf.delete();
      case (fbfe_pkg::op_type'(w.op))
         fbfe_pkg::OP_DATA: begin
            if (w.first) begin
               frames_opened++;
               encode_byte(fbfe_pkg::FRAME_FLAG);
               frame_sum = w.len;
               encode_stuffed(w.len);
            end
            frame_sum = frame_sum + w.data;
            encode_stuffed(w.data);
            if (w.last)
               encode_stuffed(CHECK_BASE - frame_sum);
         end
         fbfe_pkg::OP_EMPTY: begin
            frames_opened++;
            encode_byte(fbfe_pkg::FRAME_FLAG);
            frame_sum = 8'h00;
            encode_stuffed(8'h00);
            encode_stuffed(CHECK_BASE - frame_sum);
         end
         default: encode_byte(fbfe_pkg::FILL_BYTE);
      endcase
      if (w.n_typed != 0) begin
         tone_buf.delete();
         for (int k = 0; k < w.n_typed; k++)
            tone_buf.push_back(w.typed[4*k +: 4]);
      end
      foreach (tone_buf[k]) begin
         e.tone = tone_buf[k];
         e.run_end = (k == tone_buf.size() - 1);
         e.word_idx = idx;
         tone_q.push_back(e);
      end
   endtask

   // directed table, then random frames, idles, empty frames and noise
   task automatic build_stimulus();
      int n, plen, kind;
      req_word_type w;
      word_q.push_back(mk_word(fbfe_pkg::OP_IDLE, 8'h00, 0, 0, 8'h00, 4, FILL_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_RSVD, 8'hFF, 1, 1, 8'hFF, 4, FILL_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_EMPTY, 8'hFF, 1, 1, 8'hFF, 12, EMPTY_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h00, 1, 1, 8'h01, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'hFF, 1, 0, 8'hFF, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'hFF, 0, 0, 8'h00, 4, FF_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_IDLE, 8'h7E, 1, 1, 8'h7D, 4, FILL_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h7E, 0, 0, 8'hA5, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h7D, 0, 1, 8'h5A, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h80, 1, 1, 8'h01, 0, '0));  // checksum 0x7E
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h7D, 1, 1, 8'h7E, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h00, 0, 1, 8'h00, 0, '0));  // no opening
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h00, 1, 0, 8'h00, 0, '0));  // length short
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h01, 0, 0, 8'hFF, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_EMPTY, 8'h7E, 0, 0, 8'h7D, 12, EMPTY_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h02, 0, 1, 8'h00, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h7E, 1, 1, 8'h7D, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'hAA, 1, 0, 8'h55, 0, '0));
      word_q.push_back(mk_word(fbfe_pkg::OP_RSVD, 8'h7D, 0, 1, 8'h7E, 4, FILL_TONES));
      word_q.push_back(mk_word(fbfe_pkg::OP_DATA, 8'h55, 0, 1, 8'hAA, 0, '0));
      dir_n = word_q.size();

      n = 0;
      while (n < RAND_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int j = 0; j < plen; j++) begin
               if ($urandom_range(0, 9) == 0) begin
                  word_q.push_back(junk_word($urandom_range(0, 1) ? fbfe_pkg::OP_IDLE
                                                                  : fbfe_pkg::OP_RSVD));
                  n++;
               end
               w = mk_word(fbfe_pkg::OP_DATA, pick_payload(), j == 0, j == plen - 1,
                           8'(plen), 0, '0);
               if (j != 0 || $urandom_range(0, 9) == 0)
                  w.len = 8'($urandom);
               word_q.push_back(w);
               n++;
            end
         end else if (kind < 82) begin
            word_q.push_back(junk_word($urandom_range(0, 3) != 0 ? fbfe_pkg::OP_IDLE
                                                                 : fbfe_pkg::OP_RSVD));
            n++;
         end else if (kind < 90) begin
            word_q.push_back(junk_word(fbfe_pkg::OP_EMPTY));
            n++;
         end else begin
            w = junk_word(fbfe_pkg::OP_DATA);
            w.data = pick_payload();
            word_q.push_back(w);
            n++;
         end
      end
   endtask

   // result side: random stalls, calm stretches, and one long hold-off
   initial begin : drain
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_done) begin
            rsp_ready <= 1'b0;
            rsp_held = 1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1;
            rsp_held = 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
            else if ($urandom_range(0, 49) == 0)
               calm_left = $urandom_range(30, 120);
         end
      end
   end

   always @(posedge clock) begin
      tone_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         tones_checked++;
         if (tone_q.size() == 0) begin
            note_mismatch($sformatf("symbol %0d with nothing expected", rsp_symbol));
         end else begin
            e = tone_q.pop_front();
            if (rsp_symbol !== e.tone)
               note_mismatch($sformatf("word %0d: symbol %0d, expected %0d",
                                       e.word_idx, rsp_symbol, e.tone));
            if (rsp_last_of_run !== e.run_end)
               note_mismatch($sformatf("word %0d: last_of_run %b, expected %b",
                                       e.word_idx, rsp_last_of_run, e.run_end));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d symbols pending",
                  WATCH_LIMIT, tone_q.size());
         $display("** framed_byte_to_fsk_symbol_encoder: FAILED **");
         $finish;
      end
   end

   initial begin : feed
      req_word_type w;
      int gap;
      build_stimulus();
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < word_q.size(); i++) begin
         w = word_q[i];
         if (i == dir_n + 100)
            hold_asked = 1;
         // back-to-back words in some stretches and while the receiver holds off
         if (rsp_held || (i >= dir_n && ((i - dir_n) / 40) % 3 == 0))
            gap = 0;
         else
            gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_op <= w.op;
         req_data_byte <= w.data;
         req_first <= w.first;
         req_last <= w.last;
         req_packet_length <= w.len;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         predict_tones(w, i);
         words_sent++;
      end
      req_valid <= 1'b0;

      while (tone_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d request words (%0d from the table), %0d symbols checked",
               words_sent, dir_n, tones_checked);
      $display("covered %0d frames opened, %0d escaped bytes, %0d mismatches",
               frames_opened, escapes_seen, mismatches);
      if (mismatches == 0)
         $display("** framed_byte_to_fsk_symbol_encoder: PASSED **");
      else
         $display("** framed_byte_to_fsk_symbol_encoder: FAILED **");
      $finish;
   end

endmodule
